/* design/brfo_pkg.sv */
// ----------------------------------------------------------------------------
// brfo_pkg: shared types and constants for the byte ring FIFO
// Action codes, payload structs, controller states and controller commands.
// ----------------------------------------------------------------------------
package brfo_pkg;

    localparam int BRFO_DEPTH = 4096;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_POP   = 2'd1,
        ACT_PEEK  = 2'd2,
        ACT_PURGE = 2'd3
    } action_t;

    typedef struct packed {
        action_t     action;
        logic [7:0]  write_data;
        logic [11:0] peek_offset;
        logic [11:0] purge_count;
    } brfo_in_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        data_valid;
        logic        overrun;
        logic [11:0] queued_count;
        logic [11:0] free_count;
    } brfo_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
    } ctrl_cmd_t;

endpackage

/* design/brfo_ctrl.sv */
// ----------------------------------------------------------------------------
// brfo_ctrl: sequencing state machine of the byte ring FIFO
// Accepts one action, has the datapath execute it, then holds the result.
// ----------------------------------------------------------------------------
module brfo_ctrl
    import brfo_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output ctrl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        m_valid  = 1'b0;
        cmd.load = 1'b0;
        cmd.exec = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
            end
            ST_RESP: begin
                m_valid = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

/* design/brfo_datapath.sv */
// ----------------------------------------------------------------------------
// brfo_datapath: byte store, ring pointers and result registers
// Executes one latched action per exec command and holds its result.
// ----------------------------------------------------------------------------
module brfo_datapath
    import brfo_pkg::*;
#(
    parameter int DEPTH = BRFO_DEPTH
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  ctrl_cmd_t cmd,
    input  brfo_in_t  s_data,
    input  logic      cfg_we,
    input  logic      cfg_wdata,
    output brfo_out_t m_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int W  = (AW > 12) ? AW : 12;
    localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST_W  = AW'(DEPTH - 1);

    logic [7:0]    mem [DEPTH];
    logic [7:0]    mem_q_reg;

    brfo_in_t      item_reg;
    logic          ovw_reg;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [AW-1:0] count_reg, count_next;

    logic          rd_flag_reg;
    logic          valid_reg, over_reg;
    logic [11:0]   queued_reg, free_reg;

    logic          we, re, valid, over;
    logic [AW-1:0] raddr;
    logic [AW-1:0] add_opnd;
    logic [AW:0]   add_sum;
    logic [AW-1:0] add_wrap;
    logic [W-1:0]  off_ext, cnt_ext, q_ext, n_ext;
    logic [AW-1:0] n_trunc;
    logic [AW-1:0] free_next;
    logic          full;

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] idx);
        ring_next = (idx == LAST_W) ? '0 : idx + 1'b1;
    endfunction

    assign full    = (count_reg == LAST_W);
    assign off_ext = W'(item_reg.peek_offset);
    assign cnt_ext = W'(item_reg.purge_count);
    assign q_ext   = W'(count_reg);
    assign n_ext   = (cnt_ext < q_ext) ? cnt_ext : q_ext;
    // Both the peek offset (when in range) and the purge length stay below DEPTH.
    assign n_trunc = n_ext[AW-1:0];

    // One shared adder forms head plus a distance, wrapped once around the ring.
    assign add_opnd = (item_reg.action == ACT_PEEK) ? off_ext[AW-1:0] : n_trunc;
    assign add_sum  = {1'b0, head_reg} + {1'b0, add_opnd};
    always_comb begin
        if (add_sum >= DEPTH_W) begin
            add_wrap = AW'(add_sum - DEPTH_W);
        end else begin
            add_wrap = add_sum[AW-1:0];
        end
    end

    always_comb begin
        we         = 1'b0;
        re         = 1'b0;
        valid      = 1'b0;
        over       = 1'b0;
        raddr      = head_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        unique case (item_reg.action)
            ACT_WRITE: begin
                if (!full) begin
                    we         = 1'b1;
                    valid      = 1'b1;
                    tail_next  = ring_next(tail_reg);
                    count_next = count_reg + 1'b1;
                end else if (ovw_reg) begin
                    we        = 1'b1;
                    valid     = 1'b1;
                    over      = 1'b1;
                    tail_next = ring_next(tail_reg);
                    head_next = ring_next(head_reg);
                end
            end
            ACT_POP: begin
                if (count_reg != '0) begin
                    re         = 1'b1;
                    valid      = 1'b1;
                    head_next  = ring_next(head_reg);
                    count_next = count_reg - 1'b1;
                end
            end
            ACT_PEEK: begin
                if (off_ext < q_ext) begin
                    re    = 1'b1;
                    valid = 1'b1;
                    raddr = add_wrap;
                end
            end
            ACT_PURGE: begin
                if (n_ext == '0) begin
                    head_next  = '0;
                    tail_next  = '0;
                    count_next = '0;
                end else begin
                    head_next  = add_wrap;
                    count_next = count_reg - n_trunc;
                end
            end
        endcase
    end

    assign free_next = LAST_W - count_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            ovw_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                ovw_reg <= cfg_wdata;
            end
            if (cmd.exec) begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_data;
        end
        if (cmd.exec) begin
            rd_flag_reg <= re;
            valid_reg   <= valid;
            over_reg    <= over;
            queued_reg  <= 12'(count_next);
            free_reg    <= 12'(free_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && we) begin
            mem[tail_reg] <= item_reg.write_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && re) begin
            mem_q_reg <= mem[raddr];
        end
    end

    always_comb begin
        m_data.read_data    = rd_flag_reg ? mem_q_reg : 8'd0;
        m_data.data_valid   = valid_reg;
        m_data.overrun      = over_reg;
        m_data.queued_count = queued_reg;
        m_data.free_count   = free_reg;
    end

endmodule

/* design/byte_ring_fifo_overwrite_unit.sv */
// ----------------------------------------------------------------------------
// byte_ring_fifo_overwrite_unit: byte ring FIFO with optional overwrite
// Controller and datapath of a DEPTH-slot byte ring driven by action items.
// ----------------------------------------------------------------------------
// Usage:
//   Each transfer on the s_ channel carries one action (write, pop, peek or
//   purge) and yields exactly one result transfer on the m_ channel with the
//   byte read, flags, and the queued and free counts after the action.
//   The ring holds at most DEPTH-1 bytes; one slot always stays empty.
//   The cfg_ channel writes the overwrite-mode bit; it is always ready and
//   is meant to be used only while no action is in flight.
// Timing:
//   An action is taken in the idle state, executed in the next cycle (the
//   single-port byte store is written or read at that edge), and its result
//   is presented in the cycle after. The controller takes no new action
//   until the last result has been accepted, as it steps through its accept,
//   execute and respond states and the byte store read is registered.
// Reset and stalls:
//   aresetn (synchronous, active low) empties the ring and clears the
//   overwrite bit; the byte store itself is not cleared and needs no pass.
//   While the receiver stalls, the result holds steady and s_ready stays low.
// ----------------------------------------------------------------------------
module byte_ring_fifo_overwrite_unit
    import brfo_pkg::*;
#(
    parameter int DEPTH = BRFO_DEPTH
) (
    input  logic      aclk,
    input  logic      aresetn,

    input  logic      s_valid,
    output logic      s_ready,
    input  brfo_in_t  s_data,

    output logic      m_valid,
    input  logic      m_ready,
    output brfo_out_t m_data,

    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_wdata
);

    ctrl_cmd_t cmd;

    // The single register can be written in any cycle.
    assign cfg_ready = 1'b1;

    brfo_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // The datapath owns the pointers, the byte store and the result registers.
    brfo_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_data    (s_data),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_wdata (cfg_wdata),
        .m_data    (m_data)
    );

endmodule
